### rtl/u8sd_pkg.sv
// ----------------------------------------------------------------------------
// u8sd_pkg: shared types and constants for the UTF-8 stream decoder
// Request record between the front classifier and the back decoder, result
// record, and code point constants.
// ----------------------------------------------------------------------------
package u8sd_pkg;

    localparam int CP_W = 31;

    localparam logic [CP_W-1:0] REPL_CHAR      = 31'h0000_FFFD;
    localparam logic [CP_W-1:0] SURR_LO        = 31'h0000_D800;
    localparam logic [CP_W-1:0] SURR_HI        = 31'h0000_DFFF;
    localparam logic [CP_W-1:0] NONCHAR_FFFE   = 31'h0000_FFFE;
    localparam logic [CP_W-1:0] NONCHAR_FFFF   = 31'h0000_FFFF;
    localparam logic [7:0]      CONT_TAG_MASK  = 8'hC0;
    localparam logic [7:0]      CONT_DATA_MASK = 8'h3F;
    localparam logic [3:0]      MAX_SEQ_LEN    = 4'd6;

    // classified request
    typedef struct packed {
        logic       is_end;    // end-of-string marker
        logic [7:0] data;      // raw byte
        logic       is_cont;   // 10xxxxxx
        logic       is_ascii;  // 0xxxxxxx
        logic [3:0] len;       // leading ones of a lead byte (2..8)
        logic [4:0] bits;      // payload bits of a lead byte
    } item_t;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            replaced;
        logic            end_result;
        logic            string_had_error;
        logic            last_of_run;
    } result_t;

endpackage

### rtl/u8sd_front.sv
// ----------------------------------------------------------------------------
// u8sd_front: request classifier
// Splits an incoming byte into its class, sequence length and lead payload.
// ----------------------------------------------------------------------------
module u8sd_front import u8sd_pkg::*; (
    input  logic [7:0] data_byte,
    input  logic       string_end,
    output item_t      item
);

    logic [3:0] len;
    logic [7:0] lead_mask;

    always_comb begin
        if (data_byte == 8'hFF) begin
            len = 4'd8;
        end else if (data_byte[7:1] == 7'h7F) begin
            len = 4'd7;
        end else if (data_byte[7:2] == 6'h3F) begin
            len = 4'd6;
        end else if (data_byte[7:3] == 5'h1F) begin
            len = 4'd5;
        end else if (data_byte[7:4] == 4'hF) begin
            len = 4'd4;
        end else if (data_byte[7:5] == 3'h7) begin
            len = 4'd3;
        end else begin
            len = 4'd2;
        end
    end

    assign lead_mask = 8'hFF >> (len + 4'd1);

    always_comb begin
        item.is_end   = string_end;
        item.data     = data_byte;
        item.is_cont  = ((data_byte & CONT_TAG_MASK) == 8'h80);
        item.is_ascii = ~data_byte[7];
        item.len      = len;
        item.bits     = data_byte[4:0] & lead_mask[4:0];
    end

endmodule

### rtl/u8sd_queue.sv
// ----------------------------------------------------------------------------
// u8sd_queue: request queue
// Small FIFO of classified requests between front and back.
// ----------------------------------------------------------------------------
module u8sd_queue import u8sd_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output logic  head_valid,
    output item_t head_item
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    item_t         mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full       = (count_reg == CNT_FULL);
    assign head_valid = (count_reg != '0);
    assign head_item  = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### rtl/u8sd_back.sv
// ----------------------------------------------------------------------------
// u8sd_back: sequence decoder
// Holds the multi-byte sequence state, builds up to two results per request
// and drives the output register.
// ----------------------------------------------------------------------------
module u8sd_back import u8sd_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    head_valid,
    input  item_t   head_item,
    output logic    pop,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic [2:0]      rem_reg, rem_next;
    logic [CP_W-1:0] pv_reg, pv_next;
    logic            skip_reg, skip_next;
    logic            chk_reg, chk_next;
    logic            err_reg, err_next;
    logic            phase_reg, phase_next;
    logic            m_valid_reg, m_valid_next;
    result_t         m_data_reg, m_data_next;

    logic            a_v;          // leading replacement (cut short / end)
    logic            b_v;          // main result
    logic [CP_W-1:0] b_cp;
    logic            b_repl;
    logic            b_end;
    logic            b_err;
    logic            do_fresh;
    logic [CP_W-1:0] pv_shift;
    logic [7:0]      ovl_low;
    logic [7:0]      ovl_mask;
    logic            illegal_val;
    logic [1:0]      n_res;
    result_t         r0, r1;
    logic            out_free, emit;

    assign pv_shift = {pv_reg[CP_W-7:0], head_item.data[5:0]};
    assign ovl_low  = (8'h80 >> rem_reg) - 8'd1;
    assign ovl_mask = ~ovl_low & 8'h7F;
    assign illegal_val = ((pv_shift >= SURR_LO) && (pv_shift <= SURR_HI)) ||
                         (pv_shift == NONCHAR_FFFE) || (pv_shift == NONCHAR_FFFF);

    always_comb begin
        rem_next  = rem_reg;
        pv_next   = pv_reg;
        skip_next = skip_reg;
        chk_next  = chk_reg;
        err_next  = err_reg;
        a_v       = 1'b0;
        b_v       = 1'b0;
        b_cp      = '0;
        b_repl    = 1'b0;
        b_end     = 1'b0;
        b_err     = 1'b0;
        do_fresh  = 1'b0;

        if (head_item.is_end) begin
            a_v       = (rem_reg != 3'd0) && !skip_reg;
            b_v       = 1'b1;
            b_end     = 1'b1;
            b_err     = err_reg | a_v;
            rem_next  = '0;
            pv_next   = '0;
            skip_next = 1'b0;
            chk_next  = 1'b0;
        end else if (rem_reg != 3'd0 && !head_item.is_cont) begin
            // sequence cut short, byte decoded again as a new lead
            a_v      = !skip_reg;
            do_fresh = 1'b1;
        end else if (rem_reg != 3'd0) begin
            rem_next = rem_reg - 3'd1;
            if (skip_reg) begin
                // absorbed silently
            end else if (chk_reg && ((head_item.data & ovl_mask) == 8'h00)) begin
                b_v       = 1'b1;
                b_repl    = 1'b1;
                b_cp      = REPL_CHAR;
                skip_next = 1'b1;
                chk_next  = 1'b0;
            end else begin
                chk_next = 1'b0;
                pv_next  = pv_shift;
                if (rem_reg == 3'd1) begin
                    b_v    = 1'b1;
                    b_repl = illegal_val;
                    b_cp   = illegal_val ? REPL_CHAR : pv_shift;
                end
            end
        end else begin
            do_fresh = 1'b1;
        end

        if (do_fresh) begin
            skip_next = 1'b0;
            chk_next  = 1'b0;
            rem_next  = '0;
            if (head_item.is_cont) begin
                b_v    = 1'b1;
                b_repl = 1'b1;
                b_cp   = REPL_CHAR;
            end else if (head_item.is_ascii) begin
                b_v  = 1'b1;
                b_cp = {{(CP_W-8){1'b0}}, head_item.data};
            end else if (head_item.len > MAX_SEQ_LEN) begin
                // FE / FF: absorb len-1 continuations
                b_v       = 1'b1;
                b_repl    = 1'b1;
                b_cp      = REPL_CHAR;
                skip_next = 1'b1;
                rem_next  = 3'(head_item.len - 4'd1);
            end else if (head_item.len == 4'd2 && head_item.bits < 5'd2) begin
                // C0 / C1 overlong
                b_v       = 1'b1;
                b_repl    = 1'b1;
                b_cp      = REPL_CHAR;
                skip_next = 1'b1;
                rem_next  = 3'd1;
            end else begin
                chk_next = (head_item.bits == 5'd0);
                pv_next  = {{(CP_W-5){1'b0}}, head_item.bits};
                rem_next = 3'(head_item.len - 4'd1);
            end
        end

        if (head_item.is_end) begin
            err_next = 1'b0;
        end else begin
            err_next = err_reg | a_v | (b_v & b_repl);
        end
    end

    // result packing: replacement first, then main result
    always_comb begin
        r1.code_point       = b_cp;
        r1.replaced         = b_repl;
        r1.end_result       = b_end;
        r1.string_had_error = b_err;
        r1.last_of_run      = 1'b1;
        if (a_v) begin
            r0.code_point       = REPL_CHAR;
            r0.replaced         = 1'b1;
            r0.end_result       = 1'b0;
            r0.string_had_error = 1'b0;
            r0.last_of_run      = !b_v;
        end else begin
            r0 = r1;
        end
        n_res = {1'b0, a_v} + {1'b0, b_v};
    end

    assign out_free = !m_valid_reg || out_ready;
    assign emit     = head_valid && (n_res != 2'd0) && out_free;
    assign pop      = head_valid &&
                      ((n_res == 2'd0) || (out_free && ((n_res == 2'd1) || phase_reg)));

    always_comb begin
        phase_next   = phase_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (out_ready) begin
            m_valid_next = 1'b0;
        end
        if (emit) begin
            m_valid_next = 1'b1;
            m_data_next  = phase_reg ? r1 : r0;
            phase_next   = (n_res == 2'd2) && !phase_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg     <= '0;
            pv_reg      <= '0;
            skip_reg    <= 1'b0;
            chk_reg     <= 1'b0;
            err_reg     <= 1'b0;
            phase_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            m_valid_reg <= m_valid_next;
            if (pop) begin
                rem_reg  <= rem_next;
                pv_reg   <= pv_next;
                skip_reg <= skip_next;
                chk_reg  <= chk_next;
                err_reg  <= err_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign out_valid = m_valid_reg;
    assign out_data  = m_data_reg;

endmodule

### rtl/utf8_stream_decoder.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder: six-byte UTF-8 stream decoder
// Throughput: 1 request per cycle unless the result channel stalls;
// a request that yields two results passes both, one after the other,
// through the decoder's single output register.
// Reset (aresetn low, synchronous): queue emptied, sequence state and error
// flag cleared, no result pending.
// ----------------------------------------------------------------------------
module utf8_stream_decoder import u8sd_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic            aclk,
    input  logic            aresetn,
    // request channel
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [7:0]      s_data_byte,
    input  logic            s_string_end,
    // result channel
    output logic            m_valid,
    input  logic            m_ready,
    output logic [CP_W-1:0] m_code_point,
    output logic            m_replaced,
    output logic            m_end_result,
    output logic            m_string_had_error,
    output logic            m_last_of_run
);

    // Front: classify the byte (continuation / ASCII / lead length + payload)
    // on the way into the queue. The queue decouples input acceptance from
    // the decoder, so s_ready depends only on queue occupancy and a stalled
    // result channel does not immediately stall the source.
    // Back: the sequence state machine pops one request per cycle while the
    // output register can take a result; requests that yield no result
    // (mid-sequence continuation bytes, absorbed bytes) pop without output.

    item_t   in_item;
    item_t   head_item;
    logic    q_full;
    logic    head_valid;
    logic    pop;
    result_t out_data;

    u8sd_front u_front (
        .data_byte  (s_data_byte),
        .string_end (s_string_end),
        .item       (in_item)
    );

    u8sd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (s_valid),
        .push_item  (in_item),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    u8sd_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_data   (out_data)
    );

    assign s_ready            = !q_full;
    assign m_code_point       = out_data.code_point;
    assign m_replaced         = out_data.replaced;
    assign m_end_result       = out_data.end_result;
    assign m_string_had_error = out_data.string_had_error;
    assign m_last_of_run      = out_data.last_of_run;

    // the terminating result always closes its request's run
    a_end_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_end_result) |-> m_last_of_run)
        else $error("end result without last_of_run");

    // replacements always carry U+FFFD and are never the terminating result
    a_repl_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_replaced) |-> (m_code_point == REPL_CHAR && !m_end_result))
        else $error("replacement result with wrong value");

    // error flag only reported on a terminating result with zero code point
    a_err_on_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_string_had_error) |-> (m_end_result && m_code_point == '0))
        else $error("error flag outside end result");

    // the back end only pops a request that is present
    a_pop_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid)
        else $error("pop from empty queue");

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for utf8_stream_decoder
// A short directed table covers the code point extremes and many kinds of
// malformed input. It is followed by random byte streams, mostly well-formed
// sequences of 1 to 6 bytes mixed with noise, cut-off and overlong sequences.
// Each accepted request runs through a local decoder model. Every result is
// compared field by field against the oldest expected result.
// ----------------------------------------------------------------------------
module testbench import u8sd_pkg::*; ();

    localparam int         N_DIR    = 25;    // rows in the directed table
    localparam int         N_RAND   = 1200;  // random requests
    localparam int         N_QUIET  = 150;   // final requests sent with no idling
    localparam int         HOLD_AT  = 300;   // results seen before the long stall
    localparam int         HOLD_LEN = 100;   // cycles of the long stall
    localparam logic [7:0] CONT_TAG = 8'h80; // 10xxxxxx after CONT_TAG_MASK
    localparam logic [7:0] BAD_FE   = 8'hFE;
    localparam logic [7:0] BAD_FF   = 8'hFF;

    // one request, plus a hand-written expectation for table rows that have one
    typedef struct {
        logic [7:0] data_val;
        logic       eos;
        bit         typed;
        result_t    want;
    } stim_t;

    logic            aclk = 1'b0;
    logic            aresetn;
    logic            s_valid;
    logic            s_ready;
    logic [7:0]      s_data_byte;
    logic            s_string_end;
    logic            m_valid;
    logic            m_ready;
    logic [CP_W-1:0] m_code_point;
    logic            m_replaced;
    logic            m_end_result;
    logic            m_string_had_error;
    logic            m_last_of_run;

    stim_t   dir_tab [N_DIR];
    stim_t   stim_q [$];        // requests still to be sent
    result_t expected_cps [$];  // decoded results not yet seen at the output
    result_t run_q [$];         // results of the request being decoded
    result_t got_r;
    int      fails    = 0;
    int      rx_count = 0;
    bit      quiet    = 1'b0;   // set for the tail of the run: no idling

    // model state, cleared at the end of each string
    logic [2:0]      dec_rem  = '0;   // continuation bytes still due
    logic [CP_W-1:0] dec_acc  = '0;   // value assembled so far
    logic            dec_skip = 1'b0; // absorbing a bad chunk
    logic            dec_ovl  = 1'b0; // next continuation checked for overlong
    logic            dec_err  = 1'b0; // sticky string error

    utf8_stream_decoder DUT (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_data_byte        (s_data_byte),
        .s_string_end       (s_string_end),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_code_point       (m_code_point),
        .m_replaced         (m_replaced),
        .m_end_result       (m_end_result),
        .m_string_had_error (m_string_had_error),
        .m_last_of_run      (m_last_of_run)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Decoder model
    // ------------------------------------------------------------------

    // a request gives at most two results; anything beyond is dropped
    function automatic void put_cp(input logic [CP_W-1:0] cp, input logic repl);
        result_t r;
        r            = '0;
        r.code_point = cp;
        r.replaced   = repl;
        if (run_q.size() < 2)
            run_q.push_back(r);
    endfunction

    function automatic void put_repl();
        dec_err = 1'b1;
        put_cp(REPL_CHAR, 1'b1);
    endfunction

    // byte seen with nothing pending (or after a cut-short sequence)
    function automatic void lead_byte(input logic [7:0] b);
        int         len;
        logic [7:0] pay;
        dec_skip = 1'b0;
        dec_ovl  = 1'b0;
        if ((b & CONT_TAG_MASK) == CONT_TAG) begin
            put_repl();                          // stray continuation
        end else if (!b[7]) begin
            put_cp({23'd0, b}, 1'b0);            // ASCII, zero included
        end else begin
            len = 0;
            while (len < 8 && b[7 - len])
                len++;
            pay = b & (8'hFF >> (len + 1));
            if (len > MAX_SEQ_LEN) begin
                // FE / FF: one replacement, then absorb len-1 continuations
                put_repl();
                dec_skip = 1'b1;
                dec_rem  = 3'(len - 1);
            end else if (len == 2 && pay < 2) begin
                // C0 / C1 can only encode overlong forms
                put_repl();
                dec_skip = 1'b1;
                dec_rem  = 3'd1;
            end else begin
                dec_ovl = (pay == 0);
                dec_acc = {23'd0, pay};
                dec_rem = 3'(len - 1);
            end
        end
    endfunction

    function automatic void cont_byte(input logic [7:0] b);
        logic [7:0] need;
        if (dec_skip) begin
            dec_rem--;
            return;
        end
        if (dec_ovl) begin
            // payload-free lead: these bits of the first continuation must not all be 0
            need    = ~((8'h80 >> dec_rem) - 8'd1) & 8'h7F;
            dec_ovl = 1'b0;
            if ((b & need) == 0) begin
                put_repl();
                dec_skip = 1'b1;
                dec_rem--;
                return;
            end
        end
        dec_acc = {dec_acc[CP_W-7:0], b[5:0] & CONT_DATA_MASK[5:0]};
        if (dec_rem == 1) begin
            if ((dec_acc >= SURR_LO && dec_acc <= SURR_HI) ||
                    dec_acc == NONCHAR_FFFE || dec_acc == NONCHAR_FFFF)
                put_repl();
            else
                put_cp(dec_acc, 1'b0);
        end
        dec_rem--;
    endfunction

    // expected results of one accepted request, appended to expected_cps
    function automatic void utf8_decode(input stim_t it);
        result_t r;
        run_q.delete();
        if (it.eos) begin
            if (dec_rem != 0 && !dec_skip)
                put_repl();
            put_cp('0, 1'b0);
            r                  = run_q.pop_back();
            r.end_result       = 1'b1;
            r.string_had_error = dec_err;
            run_q.push_back(r);
            dec_rem  = '0;
            dec_acc  = '0;
            dec_skip = 1'b0;
            dec_ovl  = 1'b0;
            dec_err  = 1'b0;
        end else if (dec_rem != 0) begin
            if ((it.data_val & CONT_TAG_MASK) != CONT_TAG) begin
                // sequence cut short: replace it, then decode this byte afresh
                if (!dec_skip)
                    put_repl();
                dec_rem = '0;
                lead_byte(it.data_val);
            end else begin
                cont_byte(it.data_val);
            end
        end else begin
            lead_byte(it.data_val);
        end
        if (run_q.size() != 0) begin
            r             = run_q.pop_back();
            r.last_of_run = 1'b1;
            run_q.push_back(r);
        end
        // hand-written rows override the model, which still tracks the state
        if (it.typed) begin
            run_q.delete();
            run_q.push_back(it.want);
        end
        foreach (run_q[i])
            expected_cps.push_back(run_q[i]);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus construction
    // ------------------------------------------------------------------

    function automatic stim_t mk(input logic [7:0] d, input logic e, input bit t,
                                 input logic [CP_W-1:0] cp, input logic rp,
                                 input logic en, input logic er);
        stim_t s;
        s.data_val              = d;
        s.eos                   = e;
        s.typed                 = t;
        s.want                  = '0;
        s.want.code_point       = cp;
        s.want.replaced         = rp;
        s.want.end_result       = en;
        s.want.string_had_error = er;
        s.want.last_of_run      = 1'b1;
        return s;
    endfunction

    task automatic push_raw(input logic [7:0] d);
        stim_q.push_back(mk(d, 1'b0, 1'b0, '0, 1'b0, 1'b0, 1'b0));
    endtask

    // lead of a len-byte sequence with random payload, then ncont continuations
    task automatic push_seq(input int len, input int ncont);
        logic [7:0] lead;
        if (len == 1)
            lead = 8'($urandom_range(0, 127));
        else
            lead = (8'hFF << (8 - len)) |
                   (8'($urandom_range(0, 255)) & (8'hFF >> (len + 1)));
        push_raw(lead);
        repeat (ncont)
            push_raw(CONT_TAG | 8'($urandom_range(0, 63)));
    endtask

    task automatic build_stimulus();
        int          pick;
        int          len;
        int          sel;
        logic [15:0] v;

        // Directed table. typed=1 rows carry their expected result.
        dir_tab[ 0] = mk(8'h00, 0, 1, 31'h0,    0, 0, 0); // zero byte right after reset
        dir_tab[ 1] = mk(8'h7F, 0, 1, 31'h7F,   0, 0, 0); // top of ASCII
        dir_tab[ 2] = mk(8'hBF, 0, 1, REPL_CHAR, 1, 0, 0); // stray continuation
        dir_tab[ 3] = mk(BAD_FE, 0, 1, REPL_CHAR, 1, 0, 0); // illegal lead
        dir_tab[ 4] = mk(8'hC3, 0, 0, '0, 0, 0, 0);        // breaks the skip, starts 2-byte
        dir_tab[ 5] = mk(8'h41, 0, 0, '0, 0, 0, 0);        // cut short: two results
        dir_tab[ 6] = mk(8'hC0, 0, 1, REPL_CHAR, 1, 0, 0); // overlong two-byte lead
        dir_tab[ 7] = mk(8'hAF, 0, 0, '0, 0, 0, 0);        // absorbed
        dir_tab[ 8] = mk(8'hE0, 0, 0, '0, 0, 0, 0);        // overlong three-byte form
        dir_tab[ 9] = mk(8'h80, 0, 0, '0, 0, 0, 0);
        dir_tab[10] = mk(8'hED, 0, 0, '0, 0, 0, 0);        // surrogate D800
        dir_tab[11] = mk(8'hA0, 0, 0, '0, 0, 0, 0);
        dir_tab[12] = mk(8'h80, 0, 0, '0, 0, 0, 0);
        dir_tab[13] = mk(8'hEF, 0, 0, '0, 0, 0, 0);        // noncharacter FFFF
        dir_tab[14] = mk(8'hBF, 0, 0, '0, 0, 0, 0);
        dir_tab[15] = mk(8'hBF, 0, 0, '0, 0, 0, 0);
        dir_tab[16] = mk(8'hFD, 0, 0, '0, 0, 0, 0);        // largest six-byte value
        for (int i = 17; i < 22; i++)
            dir_tab[i] = mk(8'hBF, 0, 0, '0, 0, 0, 0);
        dir_tab[22] = mk(8'hE2, 0, 0, '0, 0, 0, 0);
        dir_tab[23] = mk(BAD_FF, 0, 0, '0, 0, 0, 0);        // cuts E2, then illegal lead
        dir_tab[24] = mk(8'h00, 1, 1, 31'h0, 0, 1, 1);      // end while skipping, error set

        for (int i = 0; i < N_DIR; i++)
            stim_q.push_back(dir_tab[i]);

        // Random part: mostly well-formed characters, the rest malformed input and string ends.
        while (stim_q.size() < N_DIR + N_RAND) begin
            pick = $urandom_range(0, 99);
            if (pick < 58) begin
                sel = $urandom_range(0, 9);
                len = (sel < 4) ? 1 : (sel < 6) ? 2 : sel - 3;
                push_seq(len, len - 1);
            end else if (pick < 62) begin
                // surrogate or noncharacter in a proper three-byte form
                sel = $urandom_range(0, 2);
                if (sel == 0)
                    v = SURR_LO[15:0] + 16'($urandom_range(0, SURR_HI - SURR_LO));
                else if (sel == 1)
                    v = NONCHAR_FFFE[15:0];
                else
                    v = NONCHAR_FFFF[15:0];
                push_raw(8'hE0 | v[15:12]);
                push_raw(CONT_TAG | v[11:6]);
                push_raw(CONT_TAG | v[5:0]);
            end else if (pick < 70) begin
                push_raw(8'($urandom_range(0, 255)));
            end else if (pick < 77) begin
                len = $urandom_range(2, 6);
                push_seq(len, $urandom_range(0, len - 2));
            end else if (pick < 82) begin
                push_raw($urandom_range(0, 1) ? BAD_FF : BAD_FE);
                repeat ($urandom_range(0, 8))
                    push_raw(CONT_TAG | 8'($urandom_range(0, 63)));
            end else if (pick < 89) begin
                // payload-free lead; the first continuation can rescue only a five- or six-byte form
                len = $urandom_range(2, 6);
                if (len == 2) begin
                    push_raw(8'hC0 | 8'($urandom_range(0, 1)));
                    push_raw(CONT_TAG | 8'($urandom_range(0, 63)));
                end else begin
                    push_raw(8'hFF << (8 - len));
                    push_raw(CONT_TAG | (8'($urandom_range(0, 63)) & 8'h0F));
                    repeat (len - 2)
                        push_raw(CONT_TAG | 8'($urandom_range(0, 63)));
                end
            end else begin
                stim_q.push_back(mk(8'($urandom_range(0, 255)), 1'b1, 1'b0, '0, 0, 0, 0));
            end
        end
        // close the last string
        stim_q.push_back(mk(8'($urandom_range(0, 255)), 1'b1, 1'b0, '0, 0, 0, 0));
    endtask

    // ------------------------------------------------------------------
    // Request side: reset, then one request per handshake
    // ------------------------------------------------------------------
    initial begin : sender
        stim_t cur;
        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_data_byte  <= '0;
        s_string_end <= 1'b0;
        build_stimulus();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        while (stim_q.size() != 0) begin
            cur   = stim_q.pop_front();
            quiet = (stim_q.size() < N_QUIET);
            // random gap; valid is only dropped when a gap follows
            if (!quiet && $urandom_range(0, 9) == 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge aclk);
            end
            s_valid      <= 1'b1;
            s_data_byte  <= cur.data_val;
            s_string_end <= cur.eos;
            @(posedge aclk);
            while (!s_ready)
                @(posedge aclk);
            // request accepted at this edge
            utf8_decode(cur);
        end
        s_valid <= 1'b0;

        // drain, then allow a few cycles for anything unexpected to show up
        while (expected_cps.size() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (fails == 0 && expected_cps.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: random stalls, plus one long hold-off that fills the
    // decoder's queue and pushes back on the request channel
    // ------------------------------------------------------------------
    initial begin : receiver
        bit held;
        held = 1'b0;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn)
            @(posedge aclk);
        forever begin
            if (!held && rx_count >= HOLD_AT) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_LEN) @(posedge aclk);
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Checker
    // ------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [CP_W-1:0] want,
                                        input logic [CP_W-1:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %h, got %h", name, want, got);
            fails++;
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            rx_count++;
            if (expected_cps.size() == 0) begin
                $error("result with nothing expected: code_point %h", m_code_point);
                fails++;
            end else begin
                got_r = expected_cps.pop_front();
                check_field("code_point", got_r.code_point, m_code_point);
                check_field("replaced", CP_W'(got_r.replaced), CP_W'(m_replaced));
                check_field("end_result", CP_W'(got_r.end_result), CP_W'(m_end_result));
                check_field("string_had_error", CP_W'(got_r.string_had_error),
                            CP_W'(m_string_had_error));
                check_field("last_of_run", CP_W'(got_r.last_of_run), CP_W'(m_last_of_run));
            end
        end
    end

    // hang guard, far beyond the slowest legal run
    initial begin : watchdog
        #5_000_000;
        $display("testbench: FAIL");
        $finish;
    end

endmodule
